>>> rtl/core/ecs_pkg.sv
`timescale 1ns / 1ps
package ecs_pkg;

    // field widths
    localparam int unsigned DISP_W  = 32;
    localparam int unsigned DENS_W  = 17;
    localparam int unsigned ENER_W  = 48;
    localparam int unsigned TOTAL_W = 63;
    localparam int unsigned N_DISP  = 8;
    localparam int unsigned S_DATA_W = 280;
    localparam int unsigned M_DATA_W = 160;

    // scaled element stiffness, KE = (5/1092) * KMAT
    localparam logic signed [7:0] KMAT [8][8] = '{
        '{ 8'sd108,  8'sd39, -8'sd66,  -8'sd3, -8'sd54, -8'sd39,  8'sd12,   8'sd3},
        '{  8'sd39, 8'sd108,   8'sd3,  8'sd12, -8'sd39, -8'sd54,  -8'sd3, -8'sd66},
        '{ -8'sd66,   8'sd3, 8'sd108, -8'sd39,  8'sd12,  -8'sd3, -8'sd54,  8'sd39},
        '{  -8'sd3,  8'sd12, -8'sd39, 8'sd108,   8'sd3, -8'sd66,  8'sd39, -8'sd54},
        '{ -8'sd54, -8'sd39,  8'sd12,   8'sd3, 8'sd108,  8'sd39, -8'sd66,  -8'sd3},
        '{ -8'sd39, -8'sd54,  -8'sd3, -8'sd66,  8'sd39, 8'sd108,   8'sd3,  8'sd12},
        '{  8'sd12,  -8'sd3, -8'sd54,  8'sd39, -8'sd66,   8'sd3, 8'sd108, -8'sd39},
        '{   8'sd3, -8'sd66,  8'sd39, -8'sd54,  -8'sd3,  8'sd12, -8'sd39, 8'sd108}
    };

    // divisor of the energy scaling after the 2^20 shift
    localparam logic [11:0] KE_DEN = 12'd1092;

    // reciprocal of 1092, exact floor for dividends below 2^27
    localparam logic [27:0] KE_RECIP    = 28'd251719696;
    localparam int unsigned KE_RECIP_SH = 38;

    typedef struct packed {
        logic       capture;
        logic       w_en;
        logic [2:0] w_row;
        logic       acc_en;
        logic [2:0] acc_row;
        logic       prep;
        logic       div_step;
        logic       e3;
        logic       m0;
        logic       m1;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

>>> rtl/core/ecs_ctrl.sv
`timescale 1ns / 1ps
module ecs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ecs_pkg::t_status i_status,
    output ecs_pkg::t_cmd    o_cmd
);
    import ecs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ROW, S_PREP, S_DIV, S_E3, S_M0, S_M1, S_FIN
    } t_state;

    t_state     r_state;
    logic [5:0] r_cnt;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.w_en     = (r_state == S_ROW) && !r_cnt[3];
        o_cmd.w_row    = r_cnt[2:0];
        o_cmd.acc_en   = (r_state == S_ROW) && (r_cnt != 6'd0);
        o_cmd.acc_row  = r_cnt[2:0] - 3'd1;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.e3       = (r_state == S_E3);
        o_cmd.m0       = (r_state == S_M0);
        o_cmd.m1       = (r_state == S_M1);
        o_cmd.fin      = (r_state == S_FIN) && !i_status.out_busy;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) r_state <= S_ROW;
                end
                S_ROW: begin
                    if (r_cnt == 6'd8) begin
                        r_cnt   <= '0;
                        r_state <= S_PREP;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_PREP: r_state <= S_DIV;
                // three 16-bit quotient digits
                S_DIV: begin
                    if (r_cnt == 6'd2) begin
                        r_cnt   <= '0;
                        r_state <= S_E3;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_E3: r_state <= S_M0;
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_FIN;
                S_FIN: begin
                    if (!i_status.out_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/ecs_dp.sv
`timescale 1ns / 1ps
module ecs_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ecs_pkg::t_cmd                  i_cmd,
    output ecs_pkg::t_status               o_status,
    input  logic [ecs_pkg::S_DATA_W-1:0]   i_data,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ecs_pkg::M_DATA_W-1:0]   o_data,
    output logic                           o_last
);
    import ecs_pkg::*;

    logic signed [DISP_W-1:0] r_u [N_DISP];
    logic [DENS_W-1:0]        r_dens;
    logic                     r_last;
    logic signed [41:0]       r_w;
    logic signed [76:0]       r_q;
    logic [33:0]              r_d2;
    logic                     r_sat;
    logic [10:0]              r_rem;
    logic [47:0]              r_sh;
    logic [ENER_W-1:0]        r_energy;
    logic [49:0]              r_e3;
    logic [83:0]              r_p;
    logic [TOTAL_W-1:0]       r_sum;
    logic                     r_out_valid;
    logic [M_DATA_W-1:0]      r_out_data;
    logic                     r_out_last;

    logic signed [42:0] n_w;
    logic signed [73:0] n_prod;
    logic [79:0]        n_x;
    logic [59:0]        n_n;
    logic [26:0]        n_t;
    logic [54:0]        n_qp;
    logic [15:0]        n_q;
    logic [26:0]        n_qd;
    logic [26:0]        n_r;
    logic [ENER_W-1:0]  n_energy;
    logic [84:0]        n_pr;
    logic [52:0]        n_hi;
    logic [47:0]        n_mag;
    logic [63:0]        n_tot;
    logic [TOTAL_W-1:0] n_total;

    // one stiffness row against the displacements
    always_comb begin
        n_w = '0;
        for (int j = 0; j < N_DISP; j++) begin
            n_w = n_w + 43'(r_u[j] * KMAT[i_cmd.w_row][j]);
        end
    end

    assign n_prod = r_u[i_cmd.acc_row] * r_w;

    // energy scaling: n = (5q + 546*2^20) >> 20, negative form clamps to zero
    always_comb begin
        if (r_q[76]) n_x = 80'd0;
        else         n_x = ({3'b0, r_q} << 2) + {3'b0, r_q};
        n_x = n_x + (80'd546 << 20);
        n_n = n_x[79:20];
    end

    // divide by 1092 one 16-bit digit per step, digit by reciprocal multiply
    assign n_t      = {r_rem, r_sh[47:32]};
    assign n_qp     = n_t * KE_RECIP;
    assign n_q      = n_qp[KE_RECIP_SH +: 16];
    assign n_qd     = n_q * KE_DEN;
    assign n_r      = n_t - n_qd;
    assign n_energy = r_sat ? {ENER_W{1'b1}} : r_sh;

    // sensitivity magnitude, rounded and clamped, and the saturated running total
    always_comb begin
        n_pr  = {1'b0, r_p} + (85'd1 << 31);
        n_hi  = n_pr[84:32];
        n_mag = (n_hi > (53'd1 << 47)) ? (48'd1 << 47) : n_hi[47:0];
        n_tot = {1'b0, r_sum} + {16'd0, r_energy};
        n_total = n_tot[63] ? {TOTAL_W{1'b1}} : n_tot[TOTAL_W-1:0];
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int j = 0; j < N_DISP; j++) begin
                r_u[j] <= i_data[j*DISP_W +: DISP_W];
            end
            r_dens <= i_data[N_DISP*DISP_W +: DENS_W];
            r_last <= i_last;
            r_q    <= '0;
        end
        if (i_cmd.w_en) r_w <= n_w[41:0];
        if (i_cmd.acc_en) r_q <= r_q + 77'(n_prod);
        if (i_cmd.prep) begin
            r_d2  <= r_dens * r_dens;
            r_sat <= (n_n >= ({48'd0, KE_DEN} << 48));
            r_rem <= n_n[58:48];
            r_sh  <= n_n[47:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= n_r[10:0];
            r_sh  <= {r_sh[31:0], n_q};
        end
        if (i_cmd.e3) begin
            r_energy <= n_energy;
            r_e3     <= ({2'b0, n_energy} << 1) + {2'b0, n_energy};
        end
        if (i_cmd.m0) r_p <= 84'(r_e3[24:0] * r_d2);
        if (i_cmd.m1) r_p <= r_p + (84'(r_e3[49:25] * r_d2) << 25);
        if (i_cmd.fin) begin
            r_out_data <= {1'b0, n_total, 48'(-n_mag), r_energy};
            r_out_last <= r_last;
        end
    end

    // running sum and output beat flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_sum       <= r_last ? '0 : n_total;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;
endmodule

>>> rtl/core/element_compliance_sensitivity_unit.sv
`timescale 1ns / 1ps
// element compliance and sensitivity unit
// input stream: one beat per quad element; s_axis_tdata carries eight
// Q12.20 displacements and a Q1.16 density, s_axis_tlast the last-element flag
// output stream: one beat per element with strain energy (Q28.20), the
// sensitivity -3*energy*density^2 (Q28.20) and the running pass total (Q43.20),
// all saturating; m_axis_tlast flags the beat that closes the pass
// sequence: row products (one stiffness row and one multiply-accumulate
// per cycle), a prep step, the divide by 1092 (one 16-bit quotient digit
// per cycle), then the density multiply and the output load
// a new element is accepted only in the idle state, after the previous
// one has been loaded into the output register
// the output register holds a finished beat while the next element is taken;
// if the receiver stalls, the next finished result waits until it is free
// reset clears the sequencer, the running total and the output valid flag
module element_compliance_sensitivity_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // disp_0 .. disp_7, density, zero pad
    input  logic [ecs_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // last_element
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // energy, sensitivity, total_energy, zero pad
    output logic [ecs_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // pass_done
    output logic                           m_axis_tlast
);
    import ecs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    ecs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ecs_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );
endmodule

>>> rtl/core/ecs_checker.sv
`timescale 1ns / 1ps
module ecs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);
    // stalled beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");

    // nothing valid right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // sensitivity is never positive
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[95] || (m_axis_tdata[95:48] == 48'd0))
        else $error("positive sensitivity");

    // zero energy gives zero sensitivity
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[47:0] == 48'd0) |-> m_axis_tdata[95:48] == 48'd0)
        else $error("sensitivity without energy");
endmodule

bind element_compliance_sensitivity_unit ecs_checker u_ecs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import ecs_pkg::*;

    typedef struct {
        logic [279:0] data;
        logic         last;
    } t_elem;

    typedef struct {
        logic [47:0] energy;
        logic [47:0] sens;
        logic [62:0] total;
        logic        done;
    } t_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [279:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tlast;

    element_compliance_sensitivity_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    t_elem pending_elems[$];
    t_res  expected_results[$];
    logic [62:0] pass_sum;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_off_left;
    bit    hold_off_req;
    int    n_mismatch;
    int    n_results;
    int    quiet_cycles;
    bit    started;

    // running compliance and sensitivity of one element
    function automatic t_res predict_element(t_elem e);
        t_res r;
        logic signed [127:0] q;
        logic signed [127:0] w;
        logic signed [31:0]  u [8];
        logic [127:0] n;
        logic [127:0] m;
        logic [63:0]  tot;
        logic [16:0]  dens;
        for (int i = 0; i < 8; i++) u[i] = e.data[32*i +: 32];
        q = 0;
        for (int i = 0; i < 8; i++) begin
            w = 0;
            for (int j = 0; j < 8; j++) w += 128'(signed'(KMAT[i][j])) * u[j];
            q += w * u[i];
        end
        if (q < 0) q = 0;
        n = (q * 5 + (128'd1092 << 19)) / (128'd1092 << 20);
        r.energy = (n > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : n[47:0];
        dens = e.data[256 +: 17];
        m = (128'(r.energy) * 3 * dens * dens + (128'd1 << 31)) >> 32;
        if (m > (128'd1 << 47)) m = 128'd1 << 47;
        r.sens = 48'(-m);
        tot = 64'(pass_sum) + 64'(r.energy);
        r.total = tot[63] ? {63{1'b1}} : tot[62:0];
        pass_sum = e.last ? '0 : r.total;
        r.done = e.last;
        return r;
    endfunction

    function automatic logic [31:0] rand_disp(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            2: return 32'($signed($urandom_range(0, 255)) - 128);
            default: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic add_elem(logic [31:0] d[8], logic [16:0] dens, logic last);
        t_elem e;
        e.data = '0;
        for (int i = 0; i < 8; i++) e.data[32*i +: 32] = d[i];
        e.data[256 +: 17] = dens;
        e.last = last;
        pending_elems.push_back(e);
    endtask

    task automatic add_random(int count);
        logic [31:0] d[8];
        int mode;
        logic [16:0] dens;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
            for (int i = 0; i < 8; i++) d[i] = rand_disp(mode);
            case ($urandom_range(0, 5))
                0: dens = 17'($urandom);
                1: dens = 17'd65536;
                2: dens = 17'd0;
                default: dens = 17'($urandom_range(0, 65536));
            endcase
            add_elem(d, dens, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic wait_drained();
        while (pending_elems.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_element(pending_elems.pop_front()));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_elems.size() > 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_elems[0].data;
                    s_axis_tlast  <= pending_elems[0].last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off
    always @(posedge i_clk) begin
        if (hold_off_req && hold_off_left == 0) hold_off_left <= 3000;
        else if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
        if (!i_rst_n || hold_off_left > 1) m_axis_tready <= 1'b0;
        else m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                t_res x;
                x = expected_results.pop_front();
                n_results++;
                if (m_axis_tdata[47:0] !== x.energy || m_axis_tdata[95:48] !== x.sens ||
                    m_axis_tdata[158:96] !== x.total || m_axis_tdata[159] !== 1'b0 ||
                    m_axis_tlast !== x.done) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("beat %0d: exp e=%h s=%h t=%h d=%b got e=%h s=%h t=%h d=%b",
                            n_results, x.energy, x.sens, x.total, x.done,
                            m_axis_tdata[47:0], m_axis_tdata[95:48],
                            m_axis_tdata[158:96], m_axis_tlast);
                end
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !started)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("element_compliance_sensitivity_unit: mismatch");
            $finish;
        end
    end

    initial begin
        logic [31:0] d[8];
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        pass_sum = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_left = 0;
        hold_off_req = 0;
        n_mismatch = 0;
        n_results = 0;
        quiet_cycles = 0;
        started = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        started = 1;
        // directed: zeros, extremes, rigid motion, density edges
        for (int i = 0; i < 8; i++) d[i] = '0;
        add_elem(d, 17'd65536, 1'b0);
        for (int i = 0; i < 8; i++) d[i] = 32'h7FFF_FFFF;
        add_elem(d, 17'd65536, 1'b0);
        for (int i = 0; i < 8; i++) d[i] = 32'h8000_0000;
        add_elem(d, 17'h1FFFF, 1'b0);
        for (int i = 0; i < 8; i++) d[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        add_elem(d, 17'h1FFFF, 1'b1);
        for (int i = 0; i < 8; i++) d[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        add_elem(d, 17'd0, 1'b0);
        for (int i = 0; i < 8; i++) d[i] = (i < 4) ? 32'h0010_0000 : 32'hFFF0_0000;
        add_elem(d, 17'd32768, 1'b1);
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 8; i++) d[i] = (i == k) ? 32'h0100_0000 : 32'h0;
            add_elem(d, 17'd1 << k * 2, k == 7);
        end
        for (int i = 0; i < 8; i++) d[i] = 32'h7FFF_FFFF;
        repeat (4) add_elem(d, 17'h1FFFF, 1'b0);
        wait_drained();
        add_random(350);
        wait_drained();
        send_idle_pct = 60;
        add_random(350);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 60;
        hold_off_req <= 1'b1;
        add_random(350);
        @(posedge i_clk);
        hold_off_req <= 1'b0;
        wait_drained();
        send_idle_pct = 23;
        recv_stall_pct = 23;
        add_random(350);
        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("ran %0d element results over four idle/stall phases with a long hold-off",
                 n_results);
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("element_compliance_sensitivity_unit: match");
        else
            $display("element_compliance_sensitivity_unit: mismatch");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/ecs_pkg.sv
rtl/core/ecs_ctrl.sv
rtl/core/ecs_dp.sv
rtl/core/element_compliance_sensitivity_unit.sv
rtl/core/ecs_checker.sv
sim/tb.sv
